FILE: design/mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
package mexp_pkg;

    localparam int WIDTH  = 31;
    localparam int CNT_W  = $clog2(WIDTH + 1);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(77807857);

    // register index as decoded from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
    } t_mm_req;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] result;
    } t_mm_rsp;

endpackage

FILE: design/mexp_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
module mexp_mulmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mexp_pkg::t_mm_req            i_req,
    input  logic [mexp_pkg::WIDTH-1:0]   i_modulus,
    output mexp_pkg::t_mm_rsp            o_rsp
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [WIDTH:0]   acc_sum;
    logic [WIDTH:0]   acc_red;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_a;

    // both operands stay below m, so one conditional subtract suffices
    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_a};
        acc_red = (acc_sum >= {1'b0, i_modulus}) ? acc_sum - {1'b0, i_modulus} : acc_sum;
        dbl     = {r_a, 1'b0};
        dbl_red = (dbl >= {1'b0, i_modulus}) ? dbl - {1'b0, i_modulus} : dbl;
        n_acc   = r_b[0] ? acc_red[WIDTH-1:0] : r_acc;
        n_a     = dbl_red[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= CNT_W'(WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_a   <= n_a;
            r_b   <= r_b >> 1;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

FILE: design/modular_exponentiation_core.sv
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
// A zero exponent or zero modulus skips the multiplier and goes straight to the done state.
// One request at a time; every step is one pass of the shared bit-serial multiplier.
// Synchronous active-low reset clears control state; modulus resets to 77807857.
module modular_exponentiation_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mexp_pkg::WIDTH-1:0]    i_base,
    input  logic [mexp_pkg::WIDTH-1:0]    i_exponent,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mexp_pkg::WIDTH-1:0]    o_power_mod,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
    input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
    output logic [mexp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_MULT   = 5'b00100,
        ST_SQUARE = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_b, n_b;
    logic [WIDTH-1:0] r_res, n_res;
    logic [WIDTH-1:0] r_out_data;
    logic             r_out_valid;
    logic             load_out;
    logic [WIDTH-1:0] one_mod;
    logic [WIDTH-1:0] exp_shift;
    logic [WIDTH-1:0] mul;
    t_mm_req          mm_req;
    t_mm_rsp          mm_rsp;

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mm_req),
        .i_modulus (r_modulus),
        .o_rsp     (mm_rsp)
    );

    assign mul       = mm_rsp.result;
    assign one_mod   = (r_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign exp_shift = r_exp >> 1;

    always_comb begin
        n_state  = r_state;
        n_exp    = r_exp;
        n_acc    = r_acc;
        n_b      = r_b;
        n_res    = r_res;
        mm_req   = '0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_exp = i_exponent;
                    n_acc = one_mod;
                    if (i_exponent == '0) begin
                        n_res   = WIDTH'(1);
                        n_state = ST_DONE;
                    end else if (r_modulus == '0) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        // base mod m as (1 mod m) * base
                        mm_req.start = 1'b1;
                        mm_req.a     = one_mod;
                        mm_req.b     = i_base;
                        n_state      = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_rsp.done) begin
                    n_b          = mul;
                    mm_req.start = 1'b1;
                    if (r_exp[0]) begin
                        mm_req.a = r_acc;
                        mm_req.b = mul;
                        n_state  = ST_MULT;
                    end else begin
                        mm_req.a = mul;
                        mm_req.b = mul;
                        n_state  = ST_SQUARE;
                    end
                end
            end
            ST_MULT: begin
                if (mm_rsp.done) begin
                    n_acc = mul;
                    // last exponent bit: the trailing square is not needed
                    if (exp_shift == '0) begin
                        n_res   = mul;
                        n_state = ST_DONE;
                    end else begin
                        mm_req.start = 1'b1;
                        mm_req.a     = r_b;
                        mm_req.b     = r_b;
                        n_state      = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                if (mm_rsp.done) begin
                    n_b   = mul;
                    n_exp = exp_shift;
                    if (exp_shift == '0) begin
                        n_res   = r_acc;
                        n_state = ST_DONE;
                    end else begin
                        mm_req.start = 1'b1;
                        if (exp_shift[0]) begin
                            mm_req.a = r_acc;
                            mm_req.b = mul;
                            n_state  = ST_MULT;
                        end else begin
                            mm_req.a = mul;
                            mm_req.b = mul;
                            n_state  = ST_SQUARE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MOD_RESET;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && paddr[2] == REG_MODULUS) begin
                r_modulus <= pwdata[WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_b   <= n_b;
        r_res <= n_res;
        if (load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_out_data;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_MODULUS) ? DATA_W'(r_modulus) : '0;

endmodule

FILE: design/mexp_checker.sv
// Port-level checks for the modular exponentiation core, bound to the top level.
module mexp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mexp_pkg::WIDTH-1:0]    o_power_mod,
    input logic                          pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_power_mod))
        else $error("result changed while stalled");

    // an accepted request leaves the core busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("core ready right after accepting a request");

    // a new result only appears after the core has been working
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a request in progress");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

FILE: sim/testbench.sv
// Testbench for modular_exponentiation_core: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module testbench;
    import mexp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 2100;
    localparam int NUM_PHASES   = 8;

    localparam logic [ADDR_W-1:0] ADDR_MODULUS = ADDR_W'(4 * 0);
    localparam logic [ADDR_W-1:0] ADDR_SPARE   = ADDR_W'(4 * 1);
    localparam logic [WIDTH-1:0]  FIELD_MAX    = {WIDTH{1'b1}};

    // Expected power_mod values, predicted when a request is accepted.
    class mexp_scoreboard;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] expected_powers[$];
        int unsigned      errors;

        function new();
            modulus = MOD_RESET;
            errors  = 0;
        endfunction

        function logic [WIDTH-1:0] calc_power_mod(logic [WIDTH-1:0] base,
                                                  logic [WIDTH-1:0] exponent);
            longint unsigned m;
            longint unsigned b;
            longint unsigned acc;
            logic [WIDTH-1:0] e;
            m = modulus;
            e = exponent;
            // zero exponent is 1 unreduced; zero modulus leaves nothing to reduce
            if (e == '0) return WIDTH'(1);
            if (m == 0) return '0;
            acc = 1 % m;
            b   = base % m;
            while (e != '0) begin
                if (e[0]) acc = (acc * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return acc[WIDTH-1:0];
        endfunction

        function void note_request(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent);
            expected_powers.push_back(calc_power_mod(base, exponent));
        endfunction

        function void check_power(logic [WIDTH-1:0] actual);
            logic [WIDTH-1:0] want;
            if (expected_powers.size() == 0) begin
                $error("power_mod: result with no request pending, expected none, actual %0d",
                       actual);
                errors++;
                return;
            end
            want = expected_powers.pop_front();
            if (actual !== want) begin
                $error("power_mod mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_powers.size();
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [WIDTH-1:0]  i_base     = '0;
    logic [WIDTH-1:0]  i_exponent = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WIDTH-1:0]  o_power_mod;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mexp_scoreboard sb = new();
    int unsigned    in_idle_pct  = 0;
    int unsigned    out_idle_pct = 0;
    int unsigned    cycle_count  = 0;

    modular_exponentiation_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_power_mod (o_power_mod),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check on handshake, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_power(o_power_mod);
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    task automatic send_request(input logic [WIDTH-1:0] base,
                                input logic [WIDTH-1:0] exponent);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(base, exponent);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODULUS) sb.modulus = data[WIDTH-1:0];
    endtask

    function automatic logic [WIDTH-1:0] pick_base(logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] r;
        r = WIDTH'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return r;
            4:          return m - 1'b1;
            5:          return m;
            6:          return m + 1'b1;
            7:          return ($urandom_range(0, 1) != 0) ? FIELD_MAX : WIDTH'($urandom_range(0, 1));
            default:    return (m != '0) ? r % m : r;
        endcase
    endfunction

    // mostly short exponents to keep the run short; some full width
    function automatic logic [WIDTH-1:0] pick_exponent();
        int unsigned      len;
        logic [WIDTH-1:0] mask;
        case ($urandom_range(0, 9))
            0, 1, 2: return WIDTH'($urandom());
            3:       return WIDTH'($urandom_range(0, 3));
            default: begin
                len  = $urandom_range(1, WIDTH);
                mask = WIDTH'((64'd1 << len) - 1);
                return (WIDTH'($urandom()) & mask) | (WIDTH'(1) << (len - 1));
            end
        endcase
    endfunction

    initial begin
        int unsigned      count;
        logic [WIDTH-1:0] m_next;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset modulus
        in_idle_pct  = 10;
        out_idle_pct = 78;
        send_request('0, '0);
        send_request('0, WIDTH'(1));
        send_request(FIELD_MAX, '0);
        send_request(FIELD_MAX, FIELD_MAX);
        send_request(WIDTH'(1), FIELD_MAX);
        send_request('0, FIELD_MAX);
        send_request(FIELD_MAX, WIDTH'(1));
        send_request(WIDTH'(2), WIDTH'(1));
        send_request(WIDTH'(2), WIDTH'(2));
        send_request(WIDTH'(2), WIDTH'(30));
        send_request(MOD_RESET, WIDTH'(5));
        send_request(MOD_RESET - 1'b1, WIDTH'(2));
        send_request(MOD_RESET + 1'b1, WIDTH'(7));
        send_request(MOD_RESET << 1, WIDTH'(3));
        send_request(WIDTH'(3), WIDTH'(31'h4000_0000));
        send_request(FIELD_MAX, WIDTH'(31'h5555_5555));
        send_request(WIDTH'(31'h2AAA_AAAA), WIDTH'(31'h2AAA_AAAA));
        send_request(WIDTH'(12345), WIDTH'(1));
        send_request(WIDTH'(5), MOD_RESET - 1'b1);
        send_request(WIDTH'(7), WIDTH'(2));
        drain_requests();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                in_idle_pct  = 10;
                out_idle_pct = 78;
            end else if (p < 5) begin
                in_idle_pct  = 78;
                out_idle_pct = 10;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            case (p)
                0: begin
                    // index 1 is not a register; modulus must stay put
                    write_reg(ADDR_SPARE, $urandom());
                    count = 40;
                end
                1: begin m_next = FIELD_MAX; count = 45; end
                2: begin m_next = WIDTH'(2); count = 30; end
                3: begin m_next = WIDTH'(1); count = 25; end
                4: begin m_next = '0;        count = 25; end
                5: begin m_next = WIDTH'($urandom()) | WIDTH'(31'h4000_0000); count = 55; end
                6: begin m_next = WIDTH'($urandom_range(3, 1000)); count = 40; end
                default: begin m_next = WIDTH'(3); count = 30; end
            endcase
            if (p != 0) write_reg(ADDR_MODULUS, {1'($urandom_range(0, 1)), m_next});
            for (int unsigned n = 0; n < count; n++) begin
                send_request(pick_base(sb.modulus), pick_exponent());
            end
            drain_requests();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: modular_exponentiation_core.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_core.sv
design/mexp_checker.sv
sim/testbench.sv
